>>> hw/rtl/linear_blend_vertex_skinning_macros.svh
// Assertion helpers shared by the skinning block.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_MACROS_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_MACROS_SVH

`define LBVS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`define LBVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lbvs_pkg.sv
package lbvs_pkg;

  localparam int unsigned BONE_COUNT     = 128;
  localparam int unsigned BONE_W         = $clog2(BONE_COUNT);
  localparam int unsigned WORDS_PER_BONE = 12;
  localparam int unsigned SLOT_W         = $clog2(WORDS_PER_BONE);
  localparam int unsigned ORIGIN_SLOT    = 9;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned WEIGHT_W       = 16;
  localparam int unsigned SHARE_W        = WEIGHT_W + 3;
  localparam int unsigned MAX_EXTRA      = 3;
  localparam int unsigned OUT_DEPTH      = 8;
  localparam int unsigned CNT_W          = $clog2(OUT_DEPTH + 1);
  localparam int unsigned WEIGHT_ONE     = 1 << WEIGHT_W;
  localparam logic [7:0]  NORMAL_SCALE   = 8'd63;
  localparam logic [8:0]  SCALE_BIAS     = 9'd192;
  localparam logic signed [9:0] BYTE_BIAS = 10'sd127;
  localparam logic signed [55:0] ROUND_BIAS = 56'sd4261478400;
  localparam logic signed [55:0] SAT_NUMER  = 56'sd8556380160;
  localparam int unsigned DEN_SHIFT      = FRAC_BITS + 1;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_VERTEX = 1'b1
  } kind_e;

  typedef struct packed {
    logic                      valid;
    logic                      first;
    logic                      last;
    logic signed [SHARE_W-1:0] weight;
    logic signed [31:0]        x;
    logic signed [31:0]        y;
    logic signed [31:0]        z;
    logic [31:0]               normal;
    logic [31:0]               tangent;
  } beat_t;

  typedef struct packed {
    logic              we;
    logic [BONE_W-1:0] waddr;
    logic [SLOT_W-1:0] wword;
    logic [31:0]       wdata;
    logic              re;
    logic [BONE_W-1:0] raddr;
  } ram_ctrl_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] normal;
    logic [31:0] tangent;
  } result_t;

  function automatic logic [31:0] sat32(input logic signed [55:0] v);
    logic [31:0] r;
    if (v > 56'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -56'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/lbvs_bone_ram.sv
module lbvs_bone_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WORDS = 12,
  parameter int unsigned WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  logic [$clog2(WORDS)-1:0]       wword_i,
  input  logic [WIDTH-1:0]               wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_i,
  output logic [WORDS-1:0][WIDTH-1:0]    rdata_o
);

  logic [WORDS-1:0][WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i][wword_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hw/rtl/lbvs_seq.sv
module lbvs_seq import lbvs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [31:0]        normal_in_i,
  input  logic [31:0]        tangent_in_i,
  input  logic [27:0]        bone_list_i,
  input  logic [47:0]        weight_list_i,
  input  logic [1:0]         extra_influences_i,
  input  logic [6:0]         load_bone_i,
  input  logic [3:0]         load_slot_i,
  input  logic signed [31:0] load_value_i,
  input  logic               out_fire_i,
  output ram_ctrl_t          ram_o,
  output beat_t              beat_o
);

  logic                busy_q, busy_d;
  logic [1:0]          ptr_q, ptr_d;
  logic [1:0]          extra_q;
  logic [BONE_W-1:0]   bones_q [MAX_EXTRA];
  logic [WEIGHT_W-1:0] w_q [MAX_EXTRA];
  logic signed [31:0]  px_q, py_q, pz_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  beat_t               beat_q, beat_d;
  logic                credit, is_load, accept, vtx;
  logic [WEIGHT_W+1:0] wsum;
  logic signed [SHARE_W-1:0] share0;

  always_comb begin
    credit     = cnt_q < CNT_W'(OUT_DEPTH);
    is_load    = kind_e'(kind_i) == KIND_LOAD;
    in_ready_o = !busy_q && (is_load || credit);
    accept     = in_valid_i && in_ready_o;
    vtx        = accept && !is_load;

    wsum = '0;
    for (int i = 0; i < MAX_EXTRA; i++) begin
      if (2'(i) < extra_influences_i) begin
        wsum = wsum + (WEIGHT_W+2)'(weight_list_i[WEIGHT_W*i +: WEIGHT_W]);
      end
    end
    share0 = $signed(SHARE_W'(WEIGHT_ONE)) - $signed({1'b0, wsum});

    ram_o.we    = accept && is_load && (load_slot_i < SLOT_W'(WORDS_PER_BONE));
    ram_o.waddr = load_bone_i;
    ram_o.wword = load_slot_i;
    ram_o.wdata = load_value_i;
    ram_o.re    = vtx || busy_q;
    ram_o.raddr = busy_q ? bones_q[ptr_q] : bone_list_i[BONE_W-1:0];

    beat_d.valid   = vtx || busy_q;
    beat_d.normal  = normal_in_i;
    beat_d.tangent = tangent_in_i;
    if (busy_q) begin
      beat_d.first  = 1'b0;
      beat_d.last   = ptr_q == (extra_q - 2'd1);
      beat_d.weight = $signed({3'b000, w_q[ptr_q]});
      beat_d.x      = px_q;
      beat_d.y      = py_q;
      beat_d.z      = pz_q;
      busy_d        = !beat_d.last;
      ptr_d         = ptr_q + 2'd1;
    end else begin
      beat_d.first  = 1'b1;
      beat_d.last   = extra_influences_i == 2'd0;
      beat_d.weight = share0;
      beat_d.x      = pos_x_i;
      beat_d.y      = pos_y_i;
      beat_d.z      = pos_z_i;
      busy_d        = vtx && (extra_influences_i != 2'd0);
      ptr_d         = 2'd0;
    end

    case ({vtx, out_fire_i})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ptr_q  <= '0;
      cnt_q  <= '0;
      beat_q <= '0;
    end else begin
      busy_q <= busy_d;
      ptr_q  <= ptr_d;
      cnt_q  <= cnt_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx) begin
      for (int i = 0; i < MAX_EXTRA; i++) begin
        bones_q[i] <= bone_list_i[BONE_W*(i+1) +: BONE_W];
        w_q[i]     <= weight_list_i[WEIGHT_W*i +: WEIGHT_W];
      end
      extra_q <= extra_influences_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      pz_q    <= pos_z_i;
    end
  end

  assign beat_o = beat_q;

endmodule

>>> hw/rtl/lbvs_xform.sv
module lbvs_xform import lbvs_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  beat_t                            beat_i,
  input  logic [WORDS_PER_BONE-1:0][31:0]  rdata_i,
  output logic                             push_o,
  output result_t                          res_o
);

  beat_t              s1_q, s2_q, s3_q;
  logic               s4v_q, s4l_q;
  logic signed [63:0] pm_q [3][3];
  logic signed [41:0] nm_q [3][3];
  logic signed [41:0] tm_q [3][3];
  logic signed [31:0] org_q [3];
  logic [31:0]        t2_q [3];
  logic signed [53:0] ns2_q [3];
  logic signed [53:0] ts2_q [3];
  logic signed [50:0] wp3_q [3];
  logic signed [53:0] ns3_q [3];
  logic signed [53:0] ts3_q [3];
  logic signed [52:0] acc_q [3];
  logic [17:0]        ncode_q [3];
  logic [17:0]        tcode_q [3];
  logic signed [31:0] pos_in [3];
  logic signed [9:0]  nb [3];
  logic signed [9:0]  tb [3];
  logic signed [49:0] ts [3];
  logic signed [43:0] nsum [3];
  logic signed [43:0] tsum [3];
  logic [8:0]         nscale, tscale;
  logic [7:0]         nbyte [3];
  logic [7:0]         tbyte [3];

  function automatic logic [17:0] code_of(input logic signed [53:0] ns);
    logic signed [55:0] numer;
    logic               neg, hi;
    numer = $signed({ns[53], ns, 1'b0}) + ROUND_BIAS;
    neg   = numer[55];
    hi    = !neg && (numer >= SAT_NUMER);
    return {neg, hi, numer[DEN_SHIFT+15:DEN_SHIFT]};
  endfunction

  function automatic logic [7:0] byte_of(input logic [17:0] code);
    logic [15:0] x;
    logic [23:0] prod;
    logic [7:0]  q0;
    logic [15:0] r;
    logic [7:0]  q;
    x    = code[15:0];
    prod = {8'b0, x} + {x, 8'b0};
    q0   = prod[23:16];
    r    = x - ({q0, 8'b0} - {8'b0, q0});
    if (code[17]) begin
      q = 8'd0;
    end else if (code[16]) begin
      q = 8'd255;
    end else if (r >= 16'd255) begin
      q = q0 + 8'd1;
    end else begin
      q = q0;
    end
    return q;
  endfunction

  always_comb begin
    pos_in[0] = beat_i.x;
    pos_in[1] = beat_i.y;
    pos_in[2] = beat_i.z;
    for (int k = 0; k < 3; k++) begin
      nb[k] = $signed({2'b00, beat_i.normal[8*k +: 8]}) - BYTE_BIAS;
      tb[k] = $signed({2'b00, beat_i.tangent[8*k +: 8]}) - BYTE_BIAS;
    end
    nscale = {1'b0, s1_q.normal[31:24]} + SCALE_BIAS;
    tscale = {1'b0, s1_q.tangent[31:24]} + SCALE_BIAS;
    for (int c = 0; c < 3; c++) begin
      ts[c] = 50'(pm_q[c][0] >>> FRAC_BITS) + 50'(pm_q[c][1] >>> FRAC_BITS)
            + 50'(pm_q[c][2] >>> FRAC_BITS) + 50'(org_q[c]);
      nsum[c] = 44'(nm_q[c][0]) + 44'(nm_q[c][1]) + 44'(nm_q[c][2]);
      tsum[c] = 44'(tm_q[c][0]) + 44'(tm_q[c][1]) + 44'(tm_q[c][2]);
      nbyte[c] = byte_of(ncode_q[c]);
      tbyte[c] = byte_of(tcode_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      s3_q  <= '0;
      s4v_q <= 1'b0;
      s4l_q <= 1'b0;
    end else begin
      s1_q  <= beat_i;
      s2_q  <= s1_q;
      s3_q  <= s2_q;
      s4v_q <= s3_q.valid;
      s4l_q <= s3_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        pm_q[c][k] <= pos_in[k] * $signed(rdata_i[k*3+c]);
        nm_q[c][k] <= nb[k] * $signed(rdata_i[k*3+c]);
        tm_q[c][k] <= tb[k] * $signed(rdata_i[k*3+c]);
      end
      org_q[c] <= $signed(rdata_i[ORIGIN_SLOT+c]);
      t2_q[c]  <= sat32(56'(ts[c]));
      ns2_q[c] <= nsum[c] * $signed({1'b0, nscale});
      ts2_q[c] <= tsum[c] * $signed({1'b0, tscale});
      wp3_q[c] <= s2_q.weight * $signed(t2_q[c]);
      ns3_q[c] <= ns2_q[c];
      ts3_q[c] <= ts2_q[c];
      if (s3_q.valid) begin
        acc_q[c] <= (s3_q.first ? 53'sd0 : acc_q[c]) + 53'(wp3_q[c]);
      end
      if (s3_q.valid && s3_q.first) begin
        ncode_q[c] <= code_of(ns3_q[c]);
        tcode_q[c] <= code_of(ts3_q[c]);
      end
    end
  end

  assign push_o      = s4v_q && s4l_q;
  assign res_o.x     = sat32(56'(acc_q[0] >>> WEIGHT_W));
  assign res_o.y     = sat32(56'(acc_q[1] >>> WEIGHT_W));
  assign res_o.z     = sat32(56'(acc_q[2] >>> WEIGHT_W));
  assign res_o.normal  = {NORMAL_SCALE, nbyte[2], nbyte[1], nbyte[0]};
  assign res_o.tangent = {NORMAL_SCALE, tbyte[2], tbyte[1], tbyte[0]};

endmodule

>>> hw/rtl/lbvs_out_fifo.sv
module lbvs_out_fifo import lbvs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o,
  output logic    full_o
);

  localparam int unsigned PTR_W = $clog2(OUT_DEPTH);

  result_t          mem_q [OUT_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;
  logic             pop;

  assign valid_o = count_q != '0;
  assign full_o  = count_q == CNT_W'(OUT_DEPTH);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> hw/rtl/linear_blend_vertex_skinning.sv
// A load word writes at most one matrix word; a vertex word reads 1 + extra_influences bones.
// The single read port of the bone matrix memory reads one bone matrix per cycle.
// Results pass read, product, sum, weight and accumulate registers, then the output queue.
// An eight-entry output queue absorbs stalls; input stalls when it would overflow.
// Reset clears all control state; the bone matrix memory is not cleared.
`include "linear_blend_vertex_skinning_macros.svh"

module linear_blend_vertex_skinning import lbvs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [31:0]        normal_in_i,
  input  logic [31:0]        tangent_in_i,
  input  logic [27:0]        bone_list_i,
  input  logic [47:0]        weight_list_i,
  input  logic [1:0]         extra_influences_i,
  input  logic [6:0]         load_bone_i,
  input  logic [3:0]         load_slot_i,
  input  logic signed [31:0] load_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [31:0]        normal_out_o,
  output logic [31:0]        tangent_out_o
);

  ram_ctrl_t                           ram_ctrl;
  beat_t                               beat;
  logic [WORDS_PER_BONE-1:0][31:0]     rdata;
  logic                                push, fifo_full, out_fire;
  logic                                multi_start;
  result_t                             res, out_res;

  assign out_fire    = out_valid_o && out_ready_i;
  assign multi_start = in_valid_i && in_ready_o && (kind_i == KIND_VERTEX)
                       && (extra_influences_i != 2'd0);

  lbvs_seq u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .pos_z_i            (pos_z_i),
    .normal_in_i        (normal_in_i),
    .tangent_in_i       (tangent_in_i),
    .bone_list_i        (bone_list_i),
    .weight_list_i      (weight_list_i),
    .extra_influences_i (extra_influences_i),
    .load_bone_i        (load_bone_i),
    .load_slot_i        (load_slot_i),
    .load_value_i       (load_value_i),
    .out_fire_i         (out_fire),
    .ram_o              (ram_ctrl),
    .beat_o             (beat)
  );

  lbvs_bone_ram #(
    .DEPTH (BONE_COUNT),
    .WORDS (WORDS_PER_BONE),
    .WIDTH (32)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_ctrl.we),
    .waddr_i (ram_ctrl.waddr),
    .wword_i (ram_ctrl.wword),
    .wdata_i (ram_ctrl.wdata),
    .re_i    (ram_ctrl.re),
    .raddr_i (ram_ctrl.raddr),
    .rdata_o (rdata)
  );

  lbvs_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .rdata_i (rdata),
    .push_o  (push),
    .res_o   (res)
  );

  lbvs_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res),
    .full_o  (fifo_full)
  );

  assign out_x_o       = out_res.x;
  assign out_y_o       = out_res.y;
  assign out_z_o       = out_res.z;
  assign normal_out_o  = out_res.normal;
  assign tangent_out_o = out_res.tangent;

  `LBVS_ASSERT_NEVER(a_no_rw_overlap, ram_ctrl.we && ram_ctrl.re, "bone write during read")
  `LBVS_ASSERT_NEVER(a_fifo_no_overflow, push && fifo_full, "result queue overflow")
  `LBVS_ASSERT_NEXT(a_multi_bone_holds, multi_start, !in_ready_o && beat.first && !beat.last, "multi-bone word not held")

endmodule

>>> tb/linear_blend_vertex_skinning_tb.sv
module linear_blend_vertex_skinning_tb;
  import lbvs_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_WORDS = 690;

  typedef longint vec3_t[3];

  typedef struct {
    logic        kind;
    logic [31:0] px, py, pz, nin, tin;
    logic [27:0] bones;
    logic [47:0] wts;
    logic [1:0]  extra;
    logic [6:0]  lbone;
    logic [3:0]  lslot;
    logic [31:0] lval;
    bit          typed;
    result_t     want;
  } skin_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, out_ready = 1'b0;
  logic in_ready, out_valid;
  logic kind = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, load_value = '0;
  logic [31:0] normal_in = '0, tangent_in = '0;
  logic [27:0] bone_list = '0;
  logic [47:0] weight_list = '0;
  logic [1:0] extra_inf = '0;
  logic [6:0] load_bone = '0;
  logic [3:0] load_slot = '0;
  logic signed [31:0] out_x, out_y, out_z;
  logic [31:0] normal_out, tangent_out;

  logic [31:0] bone_mem [0:BONE_COUNT*WORDS_PER_BONE-1];
  logic [WORDS_PER_BONE-1:0] bone_written [0:BONE_COUNT-1];
  result_t pending_results[$];
  int fails = 0;
  int cycles = 0;
  bit calm = 1'b0;
  skin_word_t directed [$];

  linear_blend_vertex_skinning dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .normal_in_i(normal_in), .tangent_in_i(tangent_in),
    .bone_list_i(bone_list), .weight_list_i(weight_list),
    .extra_influences_i(extra_inf), .load_bone_i(load_bone),
    .load_slot_i(load_slot), .load_value_i(load_value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_x_o(out_x), .out_y_o(out_y), .out_z_o(out_z),
    .normal_out_o(normal_out), .tangent_out_o(tangent_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint matrix_word(int bone, int slot);
    return longint'($signed(bone_mem[bone*WORDS_PER_BONE + slot]));
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic vec3_t transform_point(int bone, vec3_t p);
    vec3_t t;
    longint acc;
    for (int c = 0; c < 3; c++) begin
      acc = matrix_word(bone, ORIGIN_SLOT + c);
      for (int k = 0; k < 3; k++) acc += (p[k] * matrix_word(bone, 3*k + c)) >>> FRAC_BITS;
      t[c] = longint'($signed(clamp32(acc)));
    end
    return t;
  endfunction

  function automatic logic [31:0] rotate_vec(logic [31:0] pv, int bone);
    longint scale, den, n, numer, q, b;
    logic [31:0] res;
    scale = longint'(pv[31:24]) + 192;
    den = 255 << FRAC_BITS;
    res = '0;
    res[31:24] = NORMAL_SCALE;
    for (int c = 0; c < 3; c++) begin
      n = 0;
      for (int k = 0; k < 3; k++) begin
        b = longint'(pv[8*k +: 8]) - 127;
        n += b * scale * matrix_word(bone, 3*k + c);
      end
      numer = 2*n + 255*den;
      if (numer < 0) q = 0;
      else begin
        q = numer / (2*den);
        if (q > 255) q = 255;
      end
      res[8*c +: 8] = q[7:0];
    end
    return res;
  endfunction

  function automatic result_t skin_vertex(skin_word_t w);
    vec3_t p, t0, ti;
    longint acc[3];
    longint wt, wsum;
    int b0;
    result_t r;
    p[0] = longint'($signed(w.px));
    p[1] = longint'($signed(w.py));
    p[2] = longint'($signed(w.pz));
    b0 = w.bones[6:0];
    t0 = transform_point(b0, p);
    wsum = 0;
    for (int c = 0; c < 3; c++) acc[c] = 0;
    for (int i = 0; i < w.extra; i++) begin
      wt = longint'(w.wts[16*i +: 16]);
      wsum += wt;
      ti = transform_point(w.bones[7*(i+1) +: 7], p);
      for (int c = 0; c < 3; c++) acc[c] += wt * ti[c];
    end
    r.x = clamp32((acc[0] + (65536 - wsum) * t0[0]) >>> 16);
    r.y = clamp32((acc[1] + (65536 - wsum) * t0[1]) >>> 16);
    r.z = clamp32((acc[2] + (65536 - wsum) * t0[2]) >>> 16);
    r.normal = rotate_vec(w.nin, b0);
    r.tangent = rotate_vec(w.tin, b0);
    return r;
  endfunction

  function automatic void absorb_word(skin_word_t w);
    if (w.kind == KIND_LOAD) begin
      if (w.lslot < WORDS_PER_BONE) begin
        bone_mem[w.lbone*WORDS_PER_BONE + w.lslot] = w.lval;
        bone_written[w.lbone][w.lslot] = 1'b1;
      end
    end else if (w.typed) begin
      pending_results.push_back(w.want);
    end else begin
      pending_results.push_back(skin_vertex(w));
    end
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h1FFFF) - 32'h8000 + ($urandom_range(0, 1) << 16);
    endcase
  endfunction

  function automatic logic [6:0] pick_bone();
    logic [6:0] b;
    do b = $urandom_range(0, BONE_COUNT - 1); while (!(&bone_written[b]));
    return b;
  endfunction

  function automatic skin_word_t load_word(int bone, int slot, logic [31:0] value);
    skin_word_t w;
    w = '{default: '0};
    w.kind = KIND_LOAD;
    w.lbone = bone;
    w.lslot = slot;
    w.lval = value;
    w.px = $urandom;
    w.nin = $urandom;
    return w;
  endfunction

  function automatic skin_word_t vertex_word(logic [31:0] px, py, pz, nin, tin,
                                             logic [27:0] bones, logic [47:0] wts,
                                             logic [1:0] extra);
    skin_word_t w;
    w = '{default: '0};
    w.kind = KIND_VERTEX;
    w.px = px; w.py = py; w.pz = pz; w.nin = nin; w.tin = tin;
    w.bones = bones; w.wts = wts; w.extra = extra;
    w.lbone = $urandom; w.lslot = $urandom; w.lval = $urandom;
    return w;
  endfunction

  function automatic skin_word_t random_word();
    skin_word_t w;
    if ($urandom_range(0, 9) < 3) begin
      w = load_word($urandom_range(0, BONE_COUNT - 1),
                    $urandom_range(0, 7) == 0 ? $urandom_range(12, 15) : $urandom_range(0, 11),
                    rand_q16());
    end else begin
      w = vertex_word(rand_q16(), rand_q16(), rand_q16(), $urandom, $urandom,
                      {pick_bone(), pick_bone(), pick_bone(), pick_bone()},
                      {$urandom, $urandom}, $urandom_range(0, 3));
    end
    return w;
  endfunction

  task automatic send_word(skin_word_t w);
    int gap;
    kind <= w.kind;
    pos_x <= w.px; pos_y <= w.py; pos_z <= w.pz;
    normal_in <= w.nin; tangent_in <= w.tin;
    bone_list <= w.bones; weight_list <= w.wts; extra_inf <= w.extra;
    load_bone <= w.lbone; load_slot <= w.lslot; load_value <= w.lval;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    absorb_word(w);
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int gap;
    result_t want;
    @(posedge rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("unexpected result word x=%h", out_x);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (out_x !== want.x) begin
          $error("out_x expected %h actual %h", want.x, out_x); fails++;
        end
        if (out_y !== want.y) begin
          $error("out_y expected %h actual %h", want.y, out_y); fails++;
        end
        if (out_z !== want.z) begin
          $error("out_z expected %h actual %h", want.z, out_z); fails++;
        end
        if (normal_out !== want.normal) begin
          $error("normal_out expected %h actual %h", want.normal, normal_out); fails++;
        end
        if (tangent_out !== want.tangent) begin
          $error("tangent_out expected %h actual %h", want.tangent, tangent_out); fails++;
        end
      end
    end
  end

  initial begin
    skin_word_t w;
    int waited;
    for (int i = 0; i < BONE_COUNT*WORDS_PER_BONE; i++) bone_mem[i] = '0;
    for (int i = 0; i < BONE_COUNT; i++) bone_written[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int b = 0; b < BONE_COUNT; b++) begin
      if (b < 8 || b >= 120) begin
        for (int s = 0; s < WORDS_PER_BONE; s++) send_word(load_word(b, s, rand_q16()));
      end
    end

    for (int s = 0; s < WORDS_PER_BONE; s++)
      directed.push_back(load_word(1, s, (s == 0 || s == 4 || s == 8) ? 32'h1_0000 : 32'h0));
    directed.push_back(load_word(1, 15, 32'h7FFF_FFFF));
    w = vertex_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345, 32'h3FFF_007F, 32'h3F11_2233,
                    28'h0000001, 48'hFFFF_0000_1234, 2'd0);
    w.typed = 1'b1;
    w.want = '{x: 32'h7FFF_FFFF, y: 32'h8000_0000, z: 32'h0001_2345,
               normal: 32'h3FFF_007F, tangent: 32'h3F11_2233};
    directed.push_back(w);
    w = vertex_word(32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h3F00_00FF, 32'h3FFF_FF00,
                    28'h0204081, 48'hFFFF_FFFF_FFFF, 2'd3);
    w.typed = 1'b1;
    w.want = '{x: 32'h8000_0000, y: 32'h0, z: 32'hFFFF_FFFF,
               normal: 32'h3F00_00FF, tangent: 32'h3FFF_FF00};
    directed.push_back(w);
    directed.push_back(vertex_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                   32'h0000_0000, 28'hFFF_FFFF, 48'hFFFF_FFFF_FFFF, 2'd3));
    directed.push_back(vertex_word(32'h0, 32'h0, 32'h0, 32'h0, 32'hFF00_0000,
                                   28'h0, 48'h0, 2'd2));
    directed.push_back(load_word(127, 11, 32'h7FFF_FFFF));
    directed.push_back(load_word(127, 0, 32'h8000_0000));
    directed.push_back(vertex_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h80FF_7F01,
                                   32'h7F7F_7F7F, 28'hFFF_FFFF, 48'h8000_0001_FFFF, 2'd1));
    foreach (directed[i]) send_word(directed[i]);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = ((i / 100) % 4) == 3;
      send_word(random_word());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d expected result words never arrived", pending_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
